FILE: rtl/jrdb_pkg.sv
// Shared types, constants and saturation helpers for the joint row drive-bias block.
// Used by every module under rtl; depends on nothing.
package jrdb_pkg;

  // Q31.16 data word
  localparam int Q_W = 48;
  typedef logic signed [Q_W-1:0] q48_t;

  localparam q48_t QMAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q48_t QMIN = {1'b1, {(Q_W-1){1'b0}}};

  // Spring bounds: 1e6 in Q31.16
  localparam q48_t BIG_BOUND = 48'sd65536000000;

  // Row fields
  localparam int ROW_W    = 3;
  localparam int CNT_W    = 4;
  localparam int MAX_ROWS = 8;

  // Configuration port
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  // Pipeline shape
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QMUL_LAT    = 4;
  localparam int PIPE_DEPTH  = 2 * QMUL_LAT;
  // Edges from input accept to result accept:
  // front register, queue, back pipe, output register, then the result edge
  localparam int LATENCY     = PIPE_DEPTH + 3;

  // Actuator product is 60 * d, wide enough to never wrap
  localparam int ACT_W = Q_W + 7;

  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_MOTOR    = 3'd1,
    MODE_SPRING   = 3'd2,
    MODE_ACTUATOR = 3'd3,
    MODE_SERVO    = 3'd4,
    MODE_AERO     = 3'd5
  } drive_mode_e;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_ROW    = 3'd1,
    REG_TARGET = 3'd2,
    REG_GAIN_P = 3'd3,
    REG_GAIN_S = 3'd4,
    REG_SPEED  = 3'd5,
    REG_FORCE  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]       mode;
    logic [ROW_W-1:0] row;
    q48_t             target;
    q48_t             gain_p;
    q48_t             gain_s;
    q48_t             speed_cap;
    q48_t             force_cap;
  } cfg_t;

  // Classified row, as handed from front to back
  typedef struct packed {
    logic        driven;
    drive_mode_e mode;
    logic        drag_en;
    q48_t        d;
    q48_t        nbias;
    q48_t        v;
    q48_t        bias;
    q48_t        lo;
    q48_t        up;
  } item_t;

  // Saturate a 49-bit sum to the Q31.16 range
  function automatic q48_t sat49(input logic [Q_W:0] x);
    q48_t r;
    if (x[Q_W] != x[Q_W-1]) begin
      r = x[Q_W] ? QMIN : QMAX;
    end else begin
      r = x[Q_W-1:0];
    end
    return r;
  endfunction

  // Saturate the wide actuator value to the Q31.16 range
  function automatic q48_t sat_act(input logic [ACT_W-1:0] x);
    q48_t r;
    if (x[ACT_W-1:Q_W-1] == {(ACT_W-Q_W+1){x[ACT_W-1]}}) begin
      r = x[Q_W-1:0];
    end else begin
      r = x[ACT_W-1] ? QMIN : QMAX;
    end
    return r;
  endfunction

endpackage

FILE: rtl/jrdb_front.sv
// Front end: input register, row match and operand preparation.
// Depends on jrdb_pkg; pushes classified rows into jrdb_queue.
module jrdb_front import jrdb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             start,
  output logic             busy,
  input  logic [ROW_W-1:0] row_index_i,
  input  logic [CNT_W-1:0] row_total_i,
  input  q48_t             position_error_i,
  input  q48_t             bias_in_i,
  input  q48_t             lower_bound_in_i,
  input  q48_t             upper_bound_in_i,
  input  logic             full_i,
  output logic             push_o,
  output item_t            item_o
);

  logic             vld_q, vld_d;
  logic [ROW_W-1:0] idx_q;
  logic [CNT_W-1:0] cnt_q;
  q48_t             err_q, bias_q, lo_q, up_q;
  logic             accept;

  assign busy   = vld_q && full_i;
  assign accept = start && !busy;
  assign push_o = vld_q && !full_i;

  // Hold a row until the queue takes it
  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q  <= row_index_i;
      cnt_q  <= row_total_i;
      err_q  <= position_error_i;
      bias_q <= bias_in_i;
      lo_q   <= lower_bound_in_i;
      up_q   <= upper_bound_in_i;
    end
  end

  // Classify the row and prepare operands for the back end
  logic [CNT_W-1:0] cnt_lim;
  logic             mode_ok, hit;
  drive_mode_e      mode;
  logic [Q_W:0]     diff, neg_bias, neg_force, v_ext, cap_ext, ncap_ext;
  q48_t             v_clamp;

  always_comb begin
    cnt_lim = (cnt_q > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : cnt_q;
    mode_ok = cfg_i.mode inside {[MODE_MOTOR:MODE_AERO]};
    mode    = drive_mode_e'(cfg_i.mode);
    hit     = (idx_q == cfg_i.row) && ({1'b0, cfg_i.row} < cnt_lim) && mode_ok;

    diff      = {cfg_i.target[Q_W-1], cfg_i.target} - {err_q[Q_W-1], err_q};
    neg_bias  = -{bias_q[Q_W-1], bias_q};
    neg_force = -{cfg_i.force_cap[Q_W-1], cfg_i.force_cap};

    // Aero: clamp velocity to the flow limit when the limit is positive
    v_ext    = {bias_q[Q_W-1], bias_q};
    cap_ext  = {cfg_i.speed_cap[Q_W-1], cfg_i.speed_cap};
    ncap_ext = -cap_ext;
    v_clamp  = bias_q;
    if ($signed(cap_ext) > 0) begin
      if ($signed(v_ext) > $signed(cap_ext)) begin
        v_clamp = cfg_i.speed_cap;
      end else if ($signed(v_ext) < $signed(ncap_ext)) begin
        v_clamp = ncap_ext[Q_W-1:0];
      end
    end

    item_o.driven  = hit;
    item_o.mode    = hit ? mode : MODE_NONE;
    item_o.drag_en = $signed(cfg_i.gain_p) > 0;
    item_o.d       = sat49(diff);
    item_o.nbias   = sat49(neg_bias);
    item_o.v       = v_clamp;
    item_o.bias    = (hit && mode == MODE_MOTOR) ? cfg_i.target : bias_q;
    if (!hit) begin
      item_o.lo = lo_q;
      item_o.up = up_q;
    end else if (mode == MODE_SPRING) begin
      item_o.lo = -BIG_BOUND;
      item_o.up = BIG_BOUND;
    end else begin
      item_o.lo = sat49(neg_force);
      item_o.up = cfg_i.force_cap;
    end
  end

endmodule

FILE: rtl/jrdb_queue.sv
// Short queue of classified rows between front and back end.
// Depends on jrdb_pkg for item_t and the queue depth.
module jrdb_queue import jrdb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/jrdb_qmul.sv
// Four-stage Q31.16 multiplier: sign-magnitude, 24-bit partial products,
// round to nearest with ties away from zero, saturate. Depends on jrdb_pkg.
module jrdb_qmul import jrdb_pkg::*; (
  input  logic clk_i,
  input  q48_t a_i,
  input  q48_t b_i,
  input  logic b_abs_i,
  output q48_t p_o
);

  localparam int HW = Q_W / 2;

  logic             neg1_q, neg2_q, neg3_q;
  logic [Q_W-1:0]   ma_q, mb_q;
  logic [Q_W-1:0]   lo_q, m1_q, m2_q, hi_q;
  logic [Q_W+1:0]   top_q;
  logic [Q_W-1:0]   t_q;
  q48_t             p_q;

  // Stage 1: take magnitudes and the product sign
  always_ff @(posedge clk_i) begin
    neg1_q <= a_i[Q_W-1] ^ (b_i[Q_W-1] & ~b_abs_i);
    ma_q   <= a_i[Q_W-1] ? (~a_i + 1'b1) : a_i;
    mb_q   <= b_i[Q_W-1] ? (~b_i + 1'b1) : b_i;
  end

  // Stage 2: four partial products
  always_ff @(posedge clk_i) begin
    neg2_q <= neg1_q;
    lo_q   <= ma_q[HW-1:0]  * mb_q[HW-1:0];
    m1_q   <= ma_q[Q_W-1:HW] * mb_q[HW-1:0];
    m2_q   <= ma_q[HW-1:0]  * mb_q[Q_W-1:HW];
    hi_q   <= ma_q[Q_W-1:HW] * mb_q[Q_W-1:HW];
  end

  // Stage 3: combine partial products with the rounding constant
  logic [Q_W:0]   mid;
  logic [Q_W+1:0] t;
  always_comb begin
    mid = {1'b0, m1_q} + {1'b0, m2_q};
    t   = {2'b00, lo_q} + {2'b00, mid[HW-1:0], {HW{1'b0}}} + (Q_W+2)'(32'h8000);
  end

  always_ff @(posedge clk_i) begin
    neg3_q <= neg2_q;
    top_q  <= {2'b00, hi_q} + (Q_W+2)'(mid[Q_W:HW]) + (Q_W+2)'(t[Q_W+1:Q_W]);
    t_q    <= t[Q_W-1:0];
  end

  // Stage 4: drop fraction bits, saturate and restore the sign
  logic [Q_W-1:0] r;
  logic           ovf;
  always_comb begin
    ovf = |top_q[Q_W+1:16];
    r   = {top_q[15:0], t_q[Q_W-1:16]};
  end

  always_ff @(posedge clk_i) begin
    if (neg3_q) begin
      p_q <= (ovf || r[Q_W-1]) ? QMIN : -r;
    end else begin
      p_q <= (ovf || r[Q_W-1]) ? QMAX : r;
    end
  end

  assign p_o = p_q;

endmodule

FILE: rtl/jrdb_back.sv
// Back end: mode arithmetic pipeline, one row per cycle, never stalls.
// Depends on jrdb_pkg and jrdb_qmul.
module jrdb_back import jrdb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  pop_o,
  output logic  done_o,
  output q48_t  bias_out_o,
  output q48_t  lower_bound_out_o,
  output q48_t  upper_bound_out_o,
  output logic  row_driven_o
);

  localparam int MID = QMUL_LAT - 1;
  localparam int LST = PIPE_DEPTH - 1;

  logic  vld_q  [PIPE_DEPTH];
  item_t pipe_q [PIPE_DEPTH];
  item_t mid_item;
  q48_t  pa, ps, pq, b_first;

  assign pop_o = valid_i;

  // First multiply: kp*d, stiffness*d or drag*v; second: kd*(-bias)
  assign b_first = (item_i.mode == MODE_AERO) ? item_i.v : item_i.d;

  jrdb_qmul u_mul_p (
    .clk_i  (clk_i),
    .a_i    (cfg_i.gain_p),
    .b_i    (b_first),
    .b_abs_i(1'b0),
    .p_o    (pa)
  );

  jrdb_qmul u_mul_s (
    .clk_i  (clk_i),
    .a_i    (cfg_i.gain_s),
    .b_i    (item_i.nbias),
    .b_abs_i(1'b0),
    .p_o    (ps)
  );

  // Drag term: (drag*v)*|v|
  jrdb_qmul u_mul_q (
    .clk_i  (clk_i),
    .a_i    (pa),
    .b_i    (pipe_q[MID].v),
    .b_abs_i(1'b1),
    .p_o    (pq)
  );

  // Actuator: 60*d, clamp high, clamp low, saturate
  logic [ACT_W-1:0] d_ext, cap_ext, ncap_ext;
  logic [ACT_W-1:0] act_r_q, act_h_q, act_l_q;
  q48_t             act_s_q;

  always_comb begin
    d_ext    = {{(ACT_W-Q_W){item_i.d[Q_W-1]}}, item_i.d};
    cap_ext  = {{(ACT_W-Q_W){cfg_i.speed_cap[Q_W-1]}}, cfg_i.speed_cap};
    ncap_ext = -cap_ext;
  end

  always_ff @(posedge clk_i) begin
    act_r_q <= (d_ext << 6) - (d_ext << 2);
    act_h_q <= ($signed(act_r_q) > $signed(cap_ext)) ? cap_ext : act_r_q;
    act_l_q <= ($signed(act_h_q) < $signed(ncap_ext)) ? ncap_ext : act_h_q;
    act_s_q <= sat_act(act_l_q);
  end

  // Pick the bias once the first products are out
  always_comb begin
    mid_item = pipe_q[MID];
    case (pipe_q[MID].mode)
      MODE_SPRING:   mid_item.bias = pa;
      MODE_SERVO:    mid_item.bias = sat49({pa[Q_W-1], pa} + {ps[Q_W-1], ps});
      MODE_ACTUATOR: mid_item.bias = act_s_q;
      default:       mid_item.bias = pipe_q[MID].bias;
    endcase
  end

  // Side pipeline carries each row alongside the multipliers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= item_i;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      pipe_q[i] <= (i == QMUL_LAT) ? mid_item : pipe_q[i-1];
    end
  end

  // Output register: finish the drag subtraction
  logic  done_q, drv_q;
  q48_t  bias_q, lo_q, up_q;
  q48_t  last_bias;

  always_comb begin
    last_bias = pipe_q[LST].bias;
    if (pipe_q[LST].mode == MODE_AERO) begin
      last_bias = pipe_q[LST].drag_en
                ? sat49({pipe_q[LST].v[Q_W-1], pipe_q[LST].v} - {pq[Q_W-1], pq})
                : pipe_q[LST].v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[LST];
    end
  end

  always_ff @(posedge clk_i) begin
    bias_q <= last_bias;
    lo_q   <= pipe_q[LST].lo;
    up_q   <= pipe_q[LST].up;
    drv_q  <= pipe_q[LST].driven;
  end

  assign done_o            = done_q;
  assign bias_out_o        = bias_q;
  assign lower_bound_out_o = lo_q;
  assign upper_bound_out_o = up_q;
  assign row_driven_o      = drv_q;

endmodule

FILE: rtl/joint_row_drive_bias.sv
// Top level of the joint row drive-bias block: configuration registers and
// wiring of jrdb_front, jrdb_queue and jrdb_back. Depends on jrdb_pkg.
//
// One constraint row is taken per clock cycle (start high while busy is low).
// Each row produces exactly one result, shown for a single cycle with done_o
// high, in the order the rows came in. The result passes the input register,
// the queue, the back pipe and the output register; the back pipe's depth is
// set by the aero path: two chained four-stage 48-bit multipliers. The result
// cannot be held off; the back end drains the queue every cycle, so busy stays
// low in operation. Configuration is written through the APB port at byte
// address 8*i for register i; the user must write it only while no row is in
// flight, and the block itself does not enforce this.
module joint_row_drive_bias import jrdb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // row command
  input  logic              start,
  output logic              busy,
  input  logic [ROW_W-1:0]  row_index_i,
  input  logic [CNT_W-1:0]  row_total_i,
  input  q48_t              position_error_i,
  input  q48_t              bias_in_i,
  input  q48_t              lower_bound_in_i,
  input  q48_t              upper_bound_in_i,
  // result
  output logic              done_o,
  output q48_t              bias_out_o,
  output q48_t              lower_bound_out_o,
  output q48_t              upper_bound_out_o,
  output logic              row_driven_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg_q;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Write configuration registers; unknown indexes drop the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MODE:   cfg_q.mode      <= pwdata[2:0];
        REG_ROW:    cfg_q.row       <= pwdata[ROW_W-1:0];
        REG_TARGET: cfg_q.target    <= pwdata[Q_W-1:0];
        REG_GAIN_P: cfg_q.gain_p    <= pwdata[Q_W-1:0];
        REG_GAIN_S: cfg_q.gain_s    <= pwdata[Q_W-1:0];
        REG_SPEED:  cfg_q.speed_cap <= pwdata[Q_W-1:0];
        REG_FORCE:  cfg_q.force_cap <= pwdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, sign-extending the Q31.16 registers
  always_comb begin
    case (reg_sel)
      REG_MODE:   prdata = DATA_W'(cfg_q.mode);
      REG_ROW:    prdata = DATA_W'(cfg_q.row);
      REG_TARGET: prdata = {{(DATA_W-Q_W){cfg_q.target[Q_W-1]}}, cfg_q.target};
      REG_GAIN_P: prdata = {{(DATA_W-Q_W){cfg_q.gain_p[Q_W-1]}}, cfg_q.gain_p};
      REG_GAIN_S: prdata = {{(DATA_W-Q_W){cfg_q.gain_s[Q_W-1]}}, cfg_q.gain_s};
      REG_SPEED:  prdata = {{(DATA_W-Q_W){cfg_q.speed_cap[Q_W-1]}}, cfg_q.speed_cap};
      REG_FORCE:  prdata = {{(DATA_W-Q_W){cfg_q.force_cap[Q_W-1]}}, cfg_q.force_cap};
      default:    prdata = '0;
    endcase
  end

  logic  push, q_full, q_valid, pop;
  item_t push_item, head_item;

  jrdb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .start           (start),
    .busy            (busy),
    .row_index_i     (row_index_i),
    .row_total_i     (row_total_i),
    .position_error_i(position_error_i),
    .bias_in_i       (bias_in_i),
    .lower_bound_in_i(lower_bound_in_i),
    .upper_bound_in_i(upper_bound_in_i),
    .full_i          (q_full),
    .push_o          (push),
    .item_o          (push_item)
  );

  jrdb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (head_item)
  );

  jrdb_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .valid_i          (q_valid),
    .item_i           (head_item),
    .pop_o            (pop),
    .done_o           (done_o),
    .bias_out_o       (bias_out_o),
    .lower_bound_out_o(lower_bound_out_o),
    .upper_bound_out_o(upper_bound_out_o),
    .row_driven_o     (row_driven_o)
  );

`ifndef ASSERT_OFF
  // The back end drains the queue every cycle, so the front never backs up
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised: queue backed up");

  // Every accepted row yields its result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("result missing after accepted row");

  // No result without an accepted row behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without matching row");
`endif

endmodule
